>>> sv/ssb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_pkg
// Types, codes and the ordering function shared by the sprite sort batcher.
// ----------------------------------------------------------------------------
package ssb_pkg;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_END = 1'b1;

    localparam logic [1:0] MODE_DEPTH_ASC = 2'd0;
    localparam logic [1:0] MODE_DEPTH_DSC = 2'd1;
    localparam logic [1:0] MODE_TEX_ASC   = 2'd2;

    localparam logic [8:0] VERTS_PER_ENTRY = 9'd6;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] depth_key;
        logic        [15:0] texture_id;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [15:0] texture_out;
        logic [8:0]  vertex_offset;
        logic        batch_begins;
        logic [8:0]  batch_offset;
        logic        batch_ends;
        logic [8:0]  batch_vertices;
        logic        overflowed;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic        [15:0] tex;
        logic        [5:0]  arrival;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   last;
        logic   ovf;
    } q_item_t;

    typedef struct packed {
        logic empty;
        logic room;
    } q_stat_t;

    typedef struct packed {
        logic draining;
        logic filling;
    } back_stat_t;

    typedef enum logic {F_IDLE, F_FEED} front_state_t;
    typedef enum logic {B_FILL, B_DRAIN} back_state_t;

    function automatic logic goes_before(input logic [1:0] mode, input entry_t a,
                                         input entry_t b);
        logic r;
        r = 1'b0;
        case (mode)
            MODE_DEPTH_ASC: r = $signed(a.depth) < $signed(b.depth);
            MODE_DEPTH_DSC: r = $signed(b.depth) < $signed(a.depth);
            MODE_TEX_ASC:   r = a.tex < b.tex;
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/stable_sort_and_texture_batcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sort_and_texture_batcher_core
// An end beat with n stored entries reads the store into the insertion chain
// at one entry a cycle while the queue has room, then drains the chain and
// emits the n results back to back. Reset empties the store, clears the drop
// flag and sets the sort mode to texture order.
// ----------------------------------------------------------------------------
module stable_sort_and_texture_batcher_core #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ssb_pkg::in_item_t  in_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    output logic               res_strobe,
    output ssb_pkg::out_item_t result
);
    import ssb_pkg::*;

    logic        [1:0] mode_reg;
    logic              accept;
    logic              push;
    q_item_t           push_item;
    q_item_t           head;
    q_stat_t           q_stat;
    logic              pop;
    logic              front_busy;
    back_stat_t        back_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEX_ASC;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign accept = start && !busy;
    assign busy   = front_busy || !q_stat.empty || back_stat.draining;

    ssb_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item),
        .busy      (front_busy)
    );

    ssb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    ssb_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sort_mode  (mode_reg),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .stat       (back_stat),
        .res_strobe (res_strobe),
        .result     (result)
    );

    a_strobe_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> $past(back_stat.draining))
        else $error("result beat without a drain cycle");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && result.last) |-> result.batch_ends)
        else $error("final beat does not close its batch");

    a_begin_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && result.batch_begins) |-> (result.batch_offset == result.vertex_offset))
        else $error("batch offset mismatch at batch start");

    a_no_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.draining |-> !pop)
        else $error("queue popped while draining");

endmodule

>>> sv/ssb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_queue
// Short queue of entries between the store reader and the sorting chain.
// ----------------------------------------------------------------------------
module ssb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ssb_pkg::q_item_t push_item,
    input  logic             pop,
    output ssb_pkg::q_item_t head,
    output ssb_pkg::q_stat_t stat
);
    import ssb_pkg::*;

    q_item_t          slot_reg [QDEPTH];
    logic [QPW-1:0]   wp_reg, wp_next;
    logic [QPW-1:0]   rp_reg, rp_next;
    logic [QPW:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

    always_comb
    begin
        wp_next  = push ? QPW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = pop ? QPW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = QPW'(0) + cnt_reg + (QPW+1)'(push) - (QPW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head       = slot_reg[rp_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.room  = (cnt_reg < (QPW+1)'(QDEPTH - 1));

endmodule

>>> sv/ssb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_front
// Store sprite entries in arrival order; on the end beat read them out.
// ----------------------------------------------------------------------------
module ssb_front #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ssb_pkg::in_item_t in_item,
    input  ssb_pkg::q_stat_t q_stat,
    output logic             push,
    output ssb_pkg::q_item_t push_item,
    output logic             busy
);
    import ssb_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic signed [31:0] depth_mem [MAX_ENTRIES];
    logic        [15:0] tex_mem   [MAX_ENTRIES];

    front_state_t       state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               drop_reg, drop_next;
    logic [AW-1:0]      rp_reg, rp_next;
    logic               rvld_reg, rvld_next;
    logic               rlast_reg, rlast_next;
    entry_t             rdata_reg;

    logic               store_ok;
    logic               issue;
    logic               last_issue;

    assign store_ok   = fill_reg < CW'(MAX_ENTRIES);
    assign issue      = (state_reg == F_FEED) && q_stat.room;
    assign last_issue = (CW'(rp_reg) + 1'b1) == fill_reg;

    always_ff @(posedge clk)
    begin
        if (accept && in_item.op == OP_ADD && store_ok)
        begin
            depth_mem[fill_reg[AW-1:0]] <= in_item.depth_key;
            tex_mem[fill_reg[AW-1:0]]   <= in_item.texture_id;
        end
        if (issue)
        begin
            rdata_reg.depth   <= depth_mem[rp_reg];
            rdata_reg.tex     <= tex_mem[rp_reg];
            rdata_reg.arrival <= 6'(rp_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        rp_next    = rp_reg;
        rvld_next  = issue;
        rlast_next = issue && last_issue;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.op == OP_ADD)
                    begin
                        if (store_ok)
                        begin
                            fill_next = CW'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        drop_next = 1'b0;
                    end
                    else
                    begin
                        state_next = F_FEED;
                        rp_next    = '0;
                    end
                end
            end
            F_FEED:
            begin
                if (issue)
                begin
                    rp_next = AW'(rp_reg + 1'b1);
                    if (last_issue)
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (rvld_reg && rlast_reg)
        begin
            fill_next = '0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            rp_reg    <= '0;
            rvld_reg  <= 1'b0;
            rlast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            rp_reg    <= rp_next;
            rvld_reg  <= rvld_next;
            rlast_reg <= rlast_next;
        end
    end

    assign push            = rvld_reg;
    assign push_item.entry = rdata_reg;
    assign push_item.last  = rlast_reg;
    assign push_item.ovf   = drop_reg;
    assign busy            = (state_reg != F_IDLE) || rvld_reg;

endmodule

>>> sv/ssb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_back
// Insertion cell chain that sorts the frame, then drains it into batches.
// ----------------------------------------------------------------------------
module ssb_back #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         sort_mode,
    input  ssb_pkg::q_stat_t   q_stat,
    input  ssb_pkg::q_item_t   head,
    output logic               pop,
    output ssb_pkg::back_stat_t stat,
    output logic               res_strobe,
    output ssb_pkg::out_item_t result
);
    import ssb_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    back_state_t   state_reg, state_next;
    entry_t        cell_reg [MAX_ENTRIES];
    entry_t        cell_next [MAX_ENTRIES];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          first_reg, first_next;
    logic [15:0]   ptex_reg, ptex_next;
    logic [8:0]    voff_reg, voff_next;
    logic [8:0]    boff_reg, boff_next;
    logic          strobe_reg, strobe_next;
    out_item_t     res_reg, res_next;

    logic          shift_k;
    logic          prev_shift;
    entry_t        prev_cell;
    logic          begins;
    logic          ends;
    logic [8:0]    boff_cur;

    assign pop = (state_reg == B_FILL) && !q_stat.empty;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        ptex_next   = ptex_reg;
        voff_next   = voff_reg;
        boff_next   = boff_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        prev_shift  = 1'b0;
        prev_cell   = cell_reg[0];
        shift_k     = 1'b0;
        begins      = first_reg || (cell_reg[0].tex != ptex_reg);
        ends        = (cnt_reg == CW'(1)) || (cell_reg[0].tex != cell_reg[1].tex);
        boff_cur    = begins ? voff_reg : boff_reg;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            cell_next[k] = cell_reg[k];
        end
        unique case (state_reg)
            B_FILL:
            begin
                if (pop)
                begin
                    for (int k = 0; k < MAX_ENTRIES; k++)
                    begin
                        shift_k = (CW'(k) < cnt_reg)
                                  && goes_before(sort_mode, head.entry, cell_reg[k]);
                        if (!prev_shift && (shift_k || CW'(k) == cnt_reg))
                        begin
                            cell_next[k] = head.entry;
                        end
                        else if (prev_shift)
                        begin
                            cell_next[k] = prev_cell;
                        end
                        prev_shift = shift_k;
                        prev_cell  = cell_reg[k];
                    end
                    cnt_next = CW'(cnt_reg + 1'b1);
                    if (head.last)
                    begin
                        state_next = B_DRAIN;
                        ovf_next   = head.ovf;
                        first_next = 1'b1;
                        voff_next  = '0;
                        boff_next  = '0;
                    end
                end
            end
            B_DRAIN:
            begin
                for (int k = 0; k < MAX_ENTRIES - 1; k++)
                begin
                    cell_next[k] = cell_reg[k + 1];
                end
                strobe_next             = 1'b1;
                res_next.entry_index    = cell_reg[0].arrival;
                res_next.texture_out    = cell_reg[0].tex;
                res_next.vertex_offset  = voff_reg;
                res_next.batch_begins   = begins;
                res_next.batch_offset   = boff_cur;
                res_next.batch_ends     = ends;
                res_next.batch_vertices = ends ? 9'(voff_reg - boff_cur + VERTS_PER_ENTRY)
                                               : '0;
                res_next.overflowed     = ovf_reg;
                res_next.last           = (cnt_reg == CW'(1));
                first_next = 1'b0;
                ptex_next  = cell_reg[0].tex;
                boff_next  = boff_cur;
                voff_next  = 9'(voff_reg + VERTS_PER_ENTRY);
                cnt_next   = CW'(cnt_reg - 1'b1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = B_FILL;
                end
            end
            default:
            begin
                state_next = B_FILL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
        ptex_reg <= ptex_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_FILL;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            first_reg  <= 1'b1;
            voff_reg   <= '0;
            boff_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            first_reg  <= first_next;
            voff_reg   <= voff_next;
            boff_reg   <= boff_next;
            strobe_reg <= strobe_next;
        end
    end

    assign stat.draining = (state_reg == B_DRAIN);
    assign stat.filling  = (state_reg == B_FILL) && (cnt_reg != '0);
    assign res_strobe    = strobe_reg;
    assign result        = res_reg;

endmodule

>>> tb/sv/tb_stable_sort_and_texture_batcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sort_and_texture_batcher_core
// Drives sprite add and frame end beats into the sort batcher, predicts each
// emitted entry with a stable sort and batch grouping of its own, and checks
// every result beat field by field. Sort mode changes between frames.
// ----------------------------------------------------------------------------
module tb_stable_sort_and_texture_batcher_core;
    import ssb_pkg::*;

    localparam int MAX_ENTRIES = 32;
    localparam int LIMIT_CYCLES = 400000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   in_item;
    logic       cfg_we;
    logic [1:0] cfg_data;
    logic       res_strobe;
    out_item_t  result;

    stable_sort_and_texture_batcher_core #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .res_strobe(res_strobe), .result(result)
    );

    typedef struct packed {
        logic signed [31:0] depth;
        logic        [15:0] tex;
        logic        [5:0]  arrival;
    } sprite_t;

    in_item_t  pending_beats[$];
    out_item_t expected_entries[$];
    sprite_t   frame_store[MAX_ENTRIES];
    int        stored_count;
    logic      dropped;
    logic [1:0] sort_mode;
    int        error_count;
    int        cycle_count;
    logic      gaps_on;
    logic      hold_for_drain;
    int        sent_count;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic logic sorts_ahead(input sprite_t a, input sprite_t b);
        case (sort_mode)
            MODE_DEPTH_ASC: return a.depth < b.depth;
            MODE_DEPTH_DSC: return b.depth < a.depth;
            MODE_TEX_ASC:   return a.tex < b.tex;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic predict_frame(input in_item_t beat);
        int order[MAX_ENTRIES];
        int j;
        int batch_first;
        logic begins;
        logic ends;
        out_item_t o;
        if (beat.op == OP_ADD) begin
            if (stored_count < MAX_ENTRIES) begin
                frame_store[stored_count] = '{beat.depth_key, beat.texture_id,
                                              6'(stored_count)};
                stored_count++;
            end else begin
                dropped = 1'b1;
            end
            return;
        end
        for (int i = 0; i < stored_count; i++) begin
            j = i;
            while (j > 0 && sorts_ahead(frame_store[i], frame_store[order[j-1]])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        batch_first = 0;
        for (int i = 0; i < stored_count; i++) begin
            begins = (i == 0) || frame_store[order[i]].tex != frame_store[order[i-1]].tex;
            ends = (i + 1 == stored_count) ||
                   frame_store[order[i]].tex != frame_store[order[i+1]].tex;
            if (begins) batch_first = i;
            o.entry_index    = frame_store[order[i]].arrival;
            o.texture_out    = frame_store[order[i]].tex;
            o.vertex_offset  = 9'(i * 6);
            o.batch_begins   = begins;
            o.batch_offset   = 9'(batch_first * 6);
            o.batch_ends     = ends;
            o.batch_vertices = ends ? 9'((i - batch_first + 1) * 6) : 9'd0;
            o.overflowed     = dropped;
            o.last           = (i + 1 == stored_count);
            expected_entries.push_back(o);
        end
        stored_count = 0;
        dropped = 1'b0;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            in_item <= '0;
            sent_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_frame(in_item);
                sent_count <= sent_count + 1;
            end
            if (start && busy)
            begin
                // hold
            end
            else if (pending_beats.size() > 0 && !hold_for_drain &&
                     !(gaps_on && $urandom_range(99) < 17))
            begin
                in_item <= pending_beats.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && res_strobe)
        begin
            if (expected_entries.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                out_item_t w;
                w = expected_entries.pop_front();
                if (result.entry_index != w.entry_index)
                    report_mismatch("entry_index", result.entry_index, w.entry_index);
                if (result.texture_out != w.texture_out)
                    report_mismatch("texture_out", result.texture_out, w.texture_out);
                if (result.vertex_offset != w.vertex_offset)
                    report_mismatch("vertex_offset", result.vertex_offset, w.vertex_offset);
                if (result.batch_begins !== w.batch_begins)
                    report_mismatch("batch_begins", result.batch_begins, w.batch_begins);
                if (result.batch_offset != w.batch_offset)
                    report_mismatch("batch_offset", result.batch_offset, w.batch_offset);
                if (result.batch_ends !== w.batch_ends)
                    report_mismatch("batch_ends", result.batch_ends, w.batch_ends);
                if (result.batch_vertices != w.batch_vertices)
                    report_mismatch("batch_vertices", result.batch_vertices,
                                    w.batch_vertices);
                if (result.overflowed !== w.overflowed)
                    report_mismatch("overflowed", result.overflowed, w.overflowed);
                if (result.last !== w.last)
                    report_mismatch("last", result.last, w.last);
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_beat(input logic op, input logic [31:0] d, input logic [15:0] t);
        in_item_t b;
        b.op = op;
        b.depth_key = d;
        b.texture_id = t;
        pending_beats.push_back(b);
    endtask

    task automatic random_frame(input int n, input int tex_span);
        int base;
        base = $urandom_range(65535 - tex_span);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                add_beat(OP_ADD, $urandom, 16'($urandom));
            else
                add_beat(OP_ADD, {$urandom_range(3) == 0 ? $urandom : 32'($urandom_range(7))},
                         16'(base + $urandom_range(tex_span)));
        end
        add_beat(OP_END, $urandom, 16'($urandom));
    endtask

    task automatic drain_all();
        wait (pending_beats.size() == 0);
        @(posedge clk);
        while (start || busy || expected_entries.size() > 0)
            @(posedge clk);
        repeat (2 * MAX_ENTRIES + 16) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        sort_mode = m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        stored_count = 0;
        dropped = 1'b0;
        sort_mode = MODE_TEX_ASC;
        gaps_on = 1'b1;
        hold_for_drain = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset mode, extremes, empty frame, overflow, equal keys
        add_beat(OP_ADD, 32'h7FFFFFFF, 16'hFFFF);
        add_beat(OP_ADD, 32'h80000000, 16'h0000);
        add_beat(OP_ADD, 32'h00000000, 16'hFFFF);
        add_beat(OP_ADD, 32'hFFFFFFFF, 16'h0000);
        add_beat(OP_END, 32'hFFFFFFFF, 16'hFFFF);
        add_beat(OP_END, '0, '0);
        for (int i = 0; i < MAX_ENTRIES + 3; i++)
            add_beat(OP_ADD, 32'(i % 3), 16'(i % 2));
        add_beat(OP_END, '0, '0);
        add_beat(OP_ADD, 32'h5, 16'h7);
        add_beat(OP_END, '0, '0);
        drain_all();

        for (int m = 0; m < 4; m++)
        begin
            write_mode(2'(m));
            random_frame(MAX_ENTRIES + 2, 3);
            random_frame(1 + $urandom_range(10), 3);
            add_beat(OP_END, '0, '0);
            drain_all();
        end

        for (int f = 0; f < 30; f++)
        begin
            gaps_on = (f < 10 || f > 18);
            random_frame($urandom_range(15) == 0 ? MAX_ENTRIES + $urandom_range(4)
                         : 1 + $urandom_range(10), 1 + $urandom_range(7));
            if (f == 15)
            begin
                wait (pending_beats.size() == 0);
                hold_for_drain = 1'b1;
                @(posedge clk);
                while (start || busy || expected_entries.size() > 0)
                    @(posedge clk);
                hold_for_drain = 1'b0;
            end
            if (f % 8 == 7)
            begin
                drain_all();
                write_mode(2'($urandom_range(3)));
            end
        end
        drain_all();

        if (error_count == 0 && expected_entries.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
